>>> src/axis_angle_to_rotation_matrix_assert.svh
// Assertion macros for the axis-angle to rotation-matrix block.
// Depends on signals named clock and reset in the scope of each use.
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_ASSERT_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AARM_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define AARM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AARM_ASSERT_IMPL(lbl, ante, cons)
`define AARM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/aarm_pkg.sv
// Shared types, constants and tables for the axis-angle to rotation-matrix block.
// No dependencies.
`default_nettype none
package aarm_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int FRAC_BITS    = 14;
   localparam int TABLE_LEN    = 30;
   localparam int STEPS_USED   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   // Angle units: 1/128 degree for the half angle.
   localparam int HALF_TURN    = 23040;
   localparam int QUARTER_TURN = 11520;
   localparam int FULL_TURN    = 46080;

   // PI in Q30 split as HALF_TURN * PI_QUO + PI_REM.
   localparam int PI_QUO    = 146408;
   localparam int PI_REM    = 19106;
   // ceil(2^26 / 45), exact for dividends below 2^19.
   localparam int RECIP_45  = 1491309;
   localparam int RECIP_SH  = 26;
   localparam int Z_MAX     = 1686629713;

   localparam int INV_GAIN_Q30 = 652032874;

   localparam int CW = 34;   // CORDIC x and y
   localparam int ZW = 33;   // CORDIC residual angle

   localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
      30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
      30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
      30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
      30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001
   };

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [15:0] angle_deg;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } rsp_type;

   // Data that rides alongside the angle path.
   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic               neg_s;
      logic               neg_c;
   } side_type;

endpackage
`default_nettype wire

>>> src/aarm_angle.sv
// Angle front end: wraps and folds the half angle and converts it to Q30 radians.
// Depends on aarm_pkg.
`default_nettype none
module aarm_angle (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_vld,
   input  wire aarm_pkg::req_type           in_item,
   output logic                             out_vld,
   output logic signed [aarm_pkg::ZW-1:0]   out_z,
   output aarm_pkg::side_type               out_side
);

   logic signed [16:0]  h_wrap;
   logic [14:0]         m_abs;
   logic                neg_s;
   logic                neg_c;
   logic [13:0]         m_fold;

   logic                vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   aarm_pkg::side_type  side1_ff, side2_ff, side3_ff, side4_ff;
   aarm_pkg::side_type  side1_in;
   logic [13:0]         m1_ff;
   logic [31:0]         hi2_ff, hi3_ff, hi2_in;
   logic [28:0]         lo2_ff, lo2_in;
   logic [18:0]         t3;
   logic [39:0]         p3_ff, p3_in;
   logic signed [aarm_pkg::ZW-1:0] z4_ff, z4_in;

   always_comb begin
      h_wrap = 17'(in_item.angle_deg);
      if (h_wrap >= 17'(aarm_pkg::HALF_TURN)) begin
         h_wrap = h_wrap - 17'(aarm_pkg::FULL_TURN);
      end else if (h_wrap < -17'(aarm_pkg::HALF_TURN)) begin
         h_wrap = h_wrap + 17'(aarm_pkg::FULL_TURN);
      end
      neg_s  = h_wrap[16];
      m_abs  = neg_s ? 15'(-h_wrap) : 15'(h_wrap);
      neg_c  = m_abs > 15'(aarm_pkg::QUARTER_TURN);
      m_fold = neg_c ? 14'(15'(aarm_pkg::HALF_TURN) - m_abs) : 14'(m_abs);
      side1_in.axis_x = in_item.axis_x;
      side1_in.axis_y = in_item.axis_y;
      side1_in.axis_z = in_item.axis_z;
      side1_in.neg_s  = neg_s;
      side1_in.neg_c  = neg_c;
   end

   // Radians = m * PI_QUO + floor((m * PI_REM + QUARTER_TURN) / HALF_TURN).
   // The division is a shift by 9 and a reciprocal multiply by 1/45.
   always_comb begin
      hi2_in = 32'(m1_ff) * 32'(aarm_pkg::PI_QUO);
      lo2_in = 29'(m1_ff) * 29'(aarm_pkg::PI_REM) + 29'(aarm_pkg::QUARTER_TURN);
      t3     = 19'(lo2_ff >> 9);
      p3_in  = 40'(t3) * 40'(aarm_pkg::RECIP_45);
      z4_in  = aarm_pkg::ZW'(hi3_ff) + aarm_pkg::ZW'(p3_ff >> aarm_pkg::RECIP_SH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
      m1_ff    <= m_fold;
      side1_ff <= side1_in;
      hi2_ff   <= hi2_in;
      lo2_ff   <= lo2_in;
      side2_ff <= side1_ff;
      hi3_ff   <= hi2_ff;
      p3_ff    <= p3_in;
      side3_ff <= side2_ff;
      z4_ff    <= z4_in;
      side4_ff <= side3_ff;
   end

   assign out_vld  = vld4_ff;
   assign out_z    = z4_ff;
   assign out_side = side4_ff;

endmodule
`default_nettype wire

>>> src/aarm_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration, for sine and cosine.
// Depends on aarm_pkg.
`default_nettype none
module aarm_cordic (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_vld,
   input  wire logic signed [aarm_pkg::ZW-1:0] in_z,
   input  wire aarm_pkg::side_type          in_side,
   output logic                             out_vld,
   output logic signed [aarm_pkg::CW-1:0]   out_x,
   output logic signed [aarm_pkg::CW-1:0]   out_y,
   output aarm_pkg::side_type               out_side
);

   localparam int N = aarm_pkg::STEPS_USED;

   logic                           vld_ff  [N];
   logic signed [aarm_pkg::CW-1:0] x_ff    [N];
   logic signed [aarm_pkg::CW-1:0] y_ff    [N];
   logic signed [aarm_pkg::ZW-1:0] z_ff    [N];
   aarm_pkg::side_type             side_ff [N];

   for (genvar g = 0; g < N; g++) begin : g_step
      logic                           vp;
      logic signed [aarm_pkg::CW-1:0] xp, yp, dx, dy, x_in, y_in;
      logic signed [aarm_pkg::ZW-1:0] zp, at, z_in;
      aarm_pkg::side_type             sp;

      if (g == 0) begin : g_first
         assign vp = in_vld;
         assign xp = aarm_pkg::CW'(aarm_pkg::INV_GAIN_Q30);
         assign yp = '0;
         assign zp = in_z;
         assign sp = in_side;
      end else begin : g_rest
         assign vp = vld_ff[g-1];
         assign xp = x_ff[g-1];
         assign yp = y_ff[g-1];
         assign zp = z_ff[g-1];
         assign sp = side_ff[g-1];
      end

      always_comb begin
         dx = yp >>> g;
         dy = xp >>> g;
         at = aarm_pkg::ZW'(aarm_pkg::ATAN_Q30[g]);
         if (!zp[aarm_pkg::ZW-1]) begin
            x_in = xp - dx;
            y_in = yp + dy;
            z_in = zp - at;
         end else begin
            x_in = xp + dx;
            y_in = yp - dy;
            z_in = zp + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vp;
         end
         x_ff[g]    <= x_in;
         y_ff[g]    <= y_in;
         z_ff[g]    <= z_in;
         side_ff[g] <= sp;
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_x    = x_ff[N-1];
   assign out_y    = y_ff[N-1];
   assign out_side = side_ff[N-1];

endmodule
`default_nettype wire

>>> src/aarm_matrix.sv
// Quaternion and matrix back end: signs, axis scaling, pair products, rounding.
// Depends on aarm_pkg.
`default_nettype none
module aarm_matrix (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_vld,
   input  wire logic signed [aarm_pkg::CW-1:0] in_x,
   input  wire logic signed [aarm_pkg::CW-1:0] in_y,
   input  wire aarm_pkg::side_type          in_side,
   output logic                             out_vld,
   output aarm_pkg::rsp_type                out_item
);

   localparam int PW = 40;
   localparam int VW = 42;

   function automatic logic signed [15:0] round_sat(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] r;
      logic signed [VW-1:0] q;
      r = v + VW'(32768);
      q = r >>> 16;
      if (q > VW'(32767)) begin
         round_sat = 16'sh7FFF;
      end else if (q < -VW'(32768)) begin
         round_sat = 16'sh8000;
      end else begin
         round_sat = 16'(q);
      end
   endfunction

   // Stage A: signs of sine and cosine.
   logic               va_ff;
   logic signed [31:0] ca_ff, sa_ff, ca_in, sa_in;
   logic signed [15:0] ax_a_ff, ay_a_ff, az_a_ff;

   // Stage B: quaternion vector part.
   logic               vb_ff;
   logic signed [31:0] cb_ff, qx_ff, qy_ff, qz_ff, qx_in, qy_in, qz_in;
   logic signed [47:0] px, py, pz;

   // Stage C: pair products.
   logic               vc_ff;
   logic signed [63:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;

   // Stage D: entries.
   logic               vd_ff;
   aarm_pkg::rsp_type  item_ff, item_in;
   logic signed [VW-1:0] one;

   always_comb begin
      ca_in = in_side.neg_c ? 32'(-in_x) : 32'(in_x);
      sa_in = in_side.neg_s ? 32'(-in_y) : 32'(in_y);
      px = ax_a_ff * sa_ff;
      py = ay_a_ff * sa_ff;
      pz = az_a_ff * sa_ff;
      qx_in = 32'(px >>> 15);
      qy_in = 32'(py >>> 15);
      qz_in = 32'(pz >>> 15);
      pxx = qx_ff * qx_ff;
      pyy = qy_ff * qy_ff;
      pzz = qz_ff * qz_ff;
      pxy = qx_ff * qy_ff;
      pxz = qx_ff * qz_ff;
      pyz = qy_ff * qz_ff;
      pwx = cb_ff * qx_ff;
      pwy = cb_ff * qy_ff;
      pwz = cb_ff * qz_ff;
      one = VW'(1) <<< (aarm_pkg::FRAC_BITS + 16);
      item_in.m00 = round_sat(one - (VW'(yy_ff) + VW'(zz_ff)));
      item_in.m01 = round_sat(VW'(xy_ff) - VW'(wz_ff));
      item_in.m02 = round_sat(VW'(xz_ff) + VW'(wy_ff));
      item_in.m10 = round_sat(VW'(xy_ff) + VW'(wz_ff));
      item_in.m11 = round_sat(one - (VW'(xx_ff) + VW'(zz_ff)));
      item_in.m12 = round_sat(VW'(yz_ff) - VW'(wx_ff));
      item_in.m20 = round_sat(VW'(xz_ff) - VW'(wy_ff));
      item_in.m21 = round_sat(VW'(yz_ff) + VW'(wx_ff));
      item_in.m22 = round_sat(one - (VW'(xx_ff) + VW'(yy_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= in_vld;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
      ca_ff   <= ca_in;
      sa_ff   <= sa_in;
      ax_a_ff <= in_side.axis_x;
      ay_a_ff <= in_side.axis_y;
      az_a_ff <= in_side.axis_z;
      cb_ff   <= ca_ff;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      qz_ff   <= qz_in;
      // 2ab / 2^(F+14) is ab / 2^(F+13); 2cw / 2^29 is cw / 2^28.
      xx_ff   <= PW'(pxx >>> (aarm_pkg::FRAC_BITS + 13));
      yy_ff   <= PW'(pyy >>> (aarm_pkg::FRAC_BITS + 13));
      zz_ff   <= PW'(pzz >>> (aarm_pkg::FRAC_BITS + 13));
      xy_ff   <= PW'(pxy >>> (aarm_pkg::FRAC_BITS + 13));
      xz_ff   <= PW'(pxz >>> (aarm_pkg::FRAC_BITS + 13));
      yz_ff   <= PW'(pyz >>> (aarm_pkg::FRAC_BITS + 13));
      wx_ff   <= PW'(pwx >>> 28);
      wy_ff   <= PW'(pwy >>> 28);
      wz_ff   <= PW'(pwz >>> 28);
      item_ff <= item_in;
   end

   assign out_vld  = vd_ff;
   assign out_item = item_ff;

endmodule
`default_nettype wire

>>> src/axis_angle_to_rotation_matrix.sv
// Top level of the axis-angle to rotation-matrix block.
// Depends on aarm_pkg, aarm_angle, aarm_cordic, aarm_matrix and the assertion header.
//
// Usage: present an axis (Q1.14) and an angle (degrees times 64) on req_item and raise
// start. The item is taken at any rising edge where start is high and busy is low.
// busy never rises, so a new item may be given in every cycle.
// Once the item has passed through the pipeline, rsp_valid is high
// for exactly one cycle, and rsp_item then holds the nine matrix entries in Q1.14,
// rounded and saturated to 16 bits. Results leave in the order items came in.
// The pipeline is made of four stages of angle wrap and radian
// conversion, one stage per CORDIC iteration, and four stages that apply the signs,
// form the quaternion, take the pair products and round the entries.
// Throughput is one item per cycle.
// The receiver cannot stall the output, so nothing holds the pipeline.
// A synchronous reset empties the pipeline; items in flight are dropped, and the
// block keeps no state beyond the items in flight.
`default_nettype none
`include "axis_angle_to_rotation_matrix_assert.svh"
module axis_angle_to_rotation_matrix (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire aarm_pkg::req_type req_item,
   output logic                   rsp_valid,
   output aarm_pkg::rsp_type      rsp_item
);

   logic                            take;
   logic                            ang_vld;
   logic signed [aarm_pkg::ZW-1:0]  ang_z;
   aarm_pkg::side_type              ang_side;
   logic                            cor_vld;
   logic signed [aarm_pkg::CW-1:0]  cor_x;
   logic signed [aarm_pkg::CW-1:0]  cor_y;
   aarm_pkg::side_type              cor_side;

   // Every stage advances every cycle, so the block is never busy.
   assign busy = 1'b0;
   assign take = start && !busy;

   aarm_angle u_angle (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (take),
      .in_item  (req_item),
      .out_vld  (ang_vld),
      .out_z    (ang_z),
      .out_side (ang_side)
   );

   aarm_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (ang_vld),
      .in_z     (ang_z),
      .in_side  (ang_side),
      .out_vld  (cor_vld),
      .out_x    (cor_x),
      .out_y    (cor_y),
      .out_side (cor_side)
   );

   aarm_matrix u_matrix (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (cor_vld),
      .in_x     (cor_x),
      .in_y     (cor_y),
      .in_side  (cor_side),
      .out_vld  (rsp_valid),
      .out_item (rsp_item)
   );

   // The folded angle always lies in zero to a quarter turn.
   `AARM_ASSERT_IMPL(a_zrange, ang_vld, !ang_z[aarm_pkg::ZW-1] && (ang_z <= aarm_pkg::ZW'(aarm_pkg::Z_MAX)))
   // Cosine and sine of a folded angle stay near the unit range before the signs go on.
   `AARM_ASSERT_IMPL(a_unit, cor_vld, (cor_x <= aarm_pkg::CW'(1074872320)) && (cor_y >= -aarm_pkg::CW'(131072)))
   // A diagonal entry is one minus a sum of squares and never exceeds one.
   `AARM_ASSERT_IMPL(a_diag, rsp_valid, (rsp_item.m00 <= 16'sd16384) && (rsp_item.m11 <= 16'sd16384) && (rsp_item.m22 <= 16'sd16384))

endmodule
`default_nettype wire
